FILE: hdl/mau_pkg.sv
package mau_pkg;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int IDX_FLD_W   = 3;
    localparam int KIND_W      = 2;
    localparam int MODE_W      = 2;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;   // row, col, value, 2 pad bits
    localparam int M_TDATA_W   = 40;   // row, col, value, 2 pad bits
    localparam int PAYLOAD_W   = 2 * IDX_FLD_W + DATA_W;
    localparam int MAX_DIM_DEFAULT = 8;

    // Word kinds on the input stream
    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Operation codes
    localparam logic [MODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] OP_SUB   = 2'd1;
    localparam logic [MODE_W-1:0] OP_SCALE = 2'd2;
    localparam logic [MODE_W-1:0] OP_MUL   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd5;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;  // 1.0

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic cnt_clr;
        logic rd_en;
        logic out_load;
        logic err_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic size_err;
        logic last_k;
        logic last_elem;
        logic pipe_busy;
    } dp_status_t;

    // Saturate a sign-extended value to signed 32 bits
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [48:0] x);
        logic signed [DATA_W-1:0] r;
        if ((&x[48:31]) || (~|x[48:31])) begin
            r = x[31:0];
        end else if (x[48]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

FILE: hdl/mau_ram.sv
module mau_ram #(
    parameter int WIDTH = mau_pkg::DATA_W,
    parameter int DEPTH = mau_pkg::MAX_DIM_DEFAULT * mau_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/mau_ctrl.sv
module mau_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [mau_pkg::KIND_W-1:0]    s_kind,
    output logic                          s_ready,
    input  logic                          m_ready,
    output logic                          m_valid,
    input  mau_pkg::dp_status_t           st,
    output mau_pkg::ctrl_cmd_t            cmd
);
    mau_pkg::state_t state_reg, state_next;
    logic out_vld_reg, out_vld_next;
    logic accept;
    logic out_free;

    assign accept   = s_valid & s_ready;
    assign out_free = ~out_vld_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mau_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mau_pkg::ST_IDLE: begin
                if (accept && s_kind == mau_pkg::KIND_COMPUTE) begin
                    state_next = st.size_err ? mau_pkg::ST_ERR : mau_pkg::ST_RUN;
                end
            end
            mau_pkg::ST_RUN: begin
                if (st.last_k) begin
                    state_next = mau_pkg::ST_DRAIN;
                end
            end
            mau_pkg::ST_DRAIN: begin
                if (!st.pipe_busy) begin
                    state_next = mau_pkg::ST_EMIT;
                end
            end
            mau_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = st.last_elem ? mau_pkg::ST_IDLE : mau_pkg::ST_RUN;
                end
            end
            mau_pkg::ST_ERR: begin
                if (out_free) begin
                    state_next = mau_pkg::ST_IDLE;
                end
            end
            default: state_next = mau_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mau_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_a  = accept && (s_kind == mau_pkg::KIND_LOAD_A);
                cmd.load_b  = accept && (s_kind == mau_pkg::KIND_LOAD_B);
                cmd.cnt_clr = accept && (s_kind == mau_pkg::KIND_COMPUTE);
            end
            mau_pkg::ST_RUN: begin
                cmd.rd_en = 1'b1;
            end
            mau_pkg::ST_DRAIN: begin
                cmd = '0;
            end
            mau_pkg::ST_EMIT: begin
                cmd.out_load = out_free;
            end
            mau_pkg::ST_ERR: begin
                cmd.out_load = out_free;
                cmd.err_sel  = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    assign m_valid = out_vld_reg;

endmodule

FILE: hdl/mau_dp.sv
module mau_dp #(
    parameter int MAX_DIM = mau_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mau_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [mau_pkg::IDX_FLD_W-1:0]     s_row,
    input  logic [mau_pkg::IDX_FLD_W-1:0]     s_col,
    input  logic [mau_pkg::DATA_W-1:0]        s_value,
    input  mau_pkg::ctrl_cmd_t                cmd,
    output mau_pkg::dp_status_t               st,
    output logic [mau_pkg::IDX_FLD_W-1:0]     out_row,
    output logic [mau_pkg::IDX_FLD_W-1:0]     out_col,
    output logic [mau_pkg::DATA_W-1:0]        out_value,
    output logic                              out_last,
    output logic                              out_err
);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [mau_pkg::MODE_W-1:0]  op_mode_reg;
    logic [mau_pkg::DIM_W-1:0]   rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic signed [mau_pkg::DATA_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= mau_pkg::OP_ADD;
            rows_a_reg  <= mau_pkg::DIM_W'(1);
            cols_a_reg  <= mau_pkg::DIM_W'(1);
            rows_b_reg  <= mau_pkg::DIM_W'(1);
            cols_b_reg  <= mau_pkg::DIM_W'(1);
            scale_reg   <= mau_pkg::SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mau_pkg::REG_OP_MODE:      op_mode_reg <= cfg_wr_data[mau_pkg::MODE_W-1:0];
                mau_pkg::REG_ROWS_A:       rows_a_reg  <= cfg_wr_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_COLS_A:       cols_a_reg  <= cfg_wr_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_ROWS_B:       rows_b_reg  <= cfg_wr_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_COLS_B:       cols_b_reg  <= cfg_wr_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_SCALE_FACTOR: scale_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [mau_pkg::DIM_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    logic [CNT_W-1:0] ra, ca, rb, cb, nc, nk;
    logic is_mul, is_addsub;

    assign ra        = clamp_dim(rows_a_reg);
    assign ca        = clamp_dim(cols_a_reg);
    assign rb        = clamp_dim(rows_b_reg);
    assign cb        = clamp_dim(cols_b_reg);
    assign is_mul    = (op_mode_reg == mau_pkg::OP_MUL);
    assign is_addsub = (op_mode_reg == mau_pkg::OP_ADD) || (op_mode_reg == mau_pkg::OP_SUB);
    assign nc        = is_mul ? cb : ca;
    assign nk        = is_mul ? ca : CNT_W'(1);

    // loop counters: i row, j column, k inner
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic last_i, last_j, last_k;

    assign last_i = (CNT_W'(i_reg) + CNT_W'(1)) == ra;
    assign last_j = (CNT_W'(j_reg) + CNT_W'(1)) == nc;
    assign last_k = (CNT_W'(k_reg) + CNT_W'(1)) == nk;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cnt_clr) begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end else begin
            if (cmd.rd_en) begin
                k_reg <= last_k ? '0 : k_reg + IDX_W'(1);
            end
            if (cmd.out_load) begin
                if (last_j) begin
                    j_reg <= '0;
                    i_reg <= last_i ? '0 : i_reg + IDX_W'(1);
                end else begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
        end
    end

    // element stores, zero until written
    logic [ADDR_W-1:0] ld_addr, rd_addr_a, rd_addr_b;
    logic              ld_ok;
    logic [DEPTH-1:0]  va_reg, vb_reg;
    logic              va_q_reg, vb_q_reg;
    logic [mau_pkg::DATA_W-1:0] ram_a_rd, ram_b_rd;

    assign ld_ok   = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
    assign ld_addr = ADDR_W'(s_row) * ADDR_W'(MAX_DIM) + ADDR_W'(s_col);
    assign rd_addr_a = addr_of(i_reg, is_mul ? k_reg : j_reg);
    assign rd_addr_b = addr_of(is_mul ? k_reg : i_reg, j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
            vb_reg <= '0;
        end else begin
            if (cmd.load_a && ld_ok) begin
                va_reg[ld_addr] <= 1'b1;
            end
            if (cmd.load_b && ld_ok) begin
                vb_reg[ld_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            va_q_reg <= va_reg[rd_addr_a];
            vb_q_reg <= vb_reg[rd_addr_b];
        end
    end

    mau_ram #(
        .WIDTH (mau_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (cmd.load_a && ld_ok),
        .waddr (ld_addr),
        .wdata (s_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_a),
        .rdata (ram_a_rd)
    );

    mau_ram #(
        .WIDTH (mau_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (cmd.load_b && ld_ok),
        .waddr (ld_addr),
        .wdata (s_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_b),
        .rdata (ram_b_rd)
    );

    // pipeline: read -> multiply / add -> saturate and accumulate
    logic s1_vld_reg, s2_vld_reg;
    logic signed [mau_pkg::DATA_W-1:0] a_op, b_op, mul_b;
    logic signed [63:0] prod_next, prod_reg;
    logic signed [32:0] sum_next, sum_reg;
    logic signed [mau_pkg::DATA_W-1:0] term, acc_reg, acc_next;
    logic signed [32:0] acc_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= cmd.rd_en;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    assign a_op  = va_q_reg ? ram_a_rd : '0;
    assign b_op  = vb_q_reg ? ram_b_rd : '0;
    assign mul_b = is_mul ? b_op : scale_reg;
    assign prod_next = a_op * mul_b;
    assign sum_next  = (op_mode_reg == mau_pkg::OP_SUB) ? (a_op - b_op) : (a_op + b_op);

    always_ff @(posedge aclk) begin
        if (s1_vld_reg) begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    // products use floor shift by 16; add/sub use the saturated sum
    assign term = is_addsub ? mau_pkg::sat_q({{16{sum_reg[32]}}, sum_reg})
                            : mau_pkg::sat_q({prod_reg[63], prod_reg[63:16]});
    assign acc_sum  = {acc_reg[31], acc_reg} + {term[31], term};
    assign acc_next = mau_pkg::sat_q({{16{acc_sum[32]}}, acc_sum});

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cnt_clr || cmd.out_load) begin
            acc_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // output word register
    logic [mau_pkg::IDX_FLD_W-1:0] out_row_reg, out_col_reg;
    logic [mau_pkg::DATA_W-1:0]    out_value_reg;
    logic                          out_last_reg, out_err_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.err_sel) begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_value_reg <= '0;
                out_last_reg  <= 1'b1;
                out_err_reg   <= 1'b1;
            end else begin
                out_row_reg   <= mau_pkg::IDX_FLD_W'(i_reg);
                out_col_reg   <= mau_pkg::IDX_FLD_W'(j_reg);
                out_value_reg <= acc_reg;
                out_last_reg  <= last_i & last_j;
                out_err_reg   <= 1'b0;
            end
        end
    end

    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

    assign st.size_err  = (is_addsub && ((ra != rb) || (ca != cb))) || (is_mul && (ca != rb));
    assign st.last_k    = last_k;
    assign st.last_elem = last_i & last_j;
    assign st.pipe_busy = s1_vld_reg | s2_vld_reg;

endmodule

FILE: hdl/matrix_arith_unit.sv
// Channel   | Dir | Contents (low bit first)                 | Accept
// ----------+-----+------------------------------------------+----------------------
// s_axis    | in  | tuser: kind; tdata: row, col, value, pad | tvalid & tready
// m_axis    | out | tuser: size_error; tlast: last_of_run;   | tvalid & tready
//           |     | tdata: out_row, out_col, out_value, pad  |
// cfg_wr    | in  | index, data                              | cfg_wr_en
//
// Load word: taken in idle. Compute: taken in idle, then per result element
// K inner steps (K = cols_a for multiply, 1 otherwise): one store read per
// inner step, one 32x32 multiply or add/sub stage, one saturate/accumulate
// stage, then the output load. Size error: a single flagged word.
// Reset clears both stores (per-entry valid bits) and sets all config regs to defaults.
// s_axis_tready is low while a compute runs; a stalled m_axis word holds
// the datapath until taken. The final word can wait while loads go on.
module matrix_arith_unit #(
    parameter int MAX_DIM = mau_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [mau_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mau_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // row_index, col_index, element_value
    input  logic [mau_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mau_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // out_row, out_col, out_value
    output logic                              m_axis_tlast,  // last_of_run
    output logic                              m_axis_tuser   // size_error
);
    localparam int RW = mau_pkg::IDX_FLD_W;

    mau_pkg::ctrl_cmd_t  cmd;
    mau_pkg::dp_status_t st;

    logic [RW-1:0]                 out_row, out_col;
    logic [mau_pkg::DATA_W-1:0]    out_value;

    mau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .st      (st),
        .cmd     (cmd)
    );

    mau_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_row        (s_axis_tdata[RW-1:0]),
        .s_col        (s_axis_tdata[2*RW-1:RW]),
        .s_value      (s_axis_tdata[mau_pkg::PAYLOAD_W-1:2*RW]),
        .cmd          (cmd),
        .st           (st),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .out_last     (m_axis_tlast),
        .out_err      (m_axis_tuser)
    );

    assign m_axis_tdata = {{(mau_pkg::M_TDATA_W - mau_pkg::PAYLOAD_W){1'b0}},
                           out_value, out_col, out_row};

endmodule

FILE: hdl/mau_checker.sv
module mau_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mau_pkg::KIND_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mau_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic                          m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // error word is a lone, zeroed, final word
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed size error word");

    // no input taken while a run still has words to deliver
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted mid-run");

    // a taken compute word closes the input side in the following cycle
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mau_pkg::KIND_COMPUTE)
            |=> !s_axis_tready)
        else $error("ready after compute word");

endmodule

bind matrix_arith_unit mau_checker u_mau_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/matrix_arith_unit_tb.sv
`timescale 1ns / 1ps

module matrix_arith_unit_tb;
    import mau_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DEFAULT;
    localparam int CYCLE_LIMIT   = 400000;   // far above the slowest legal run
    localparam int SETTLE_CYCLES = 16;       // covers a load still in flight after the last word
    localparam int RANDOM_WORDS  = 110;
    localparam int HOLD_CYCLES   = 300;      // long receiver stall for the back-pressure test

    // kind 3 has no meaning; the block must drop it
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // one result word as seen on m_axis
    typedef struct packed {
        logic [IDX_FLD_W-1:0] row;
        logic [IDX_FLD_W-1:0] col;
        logic [DATA_W-1:0]    value;
        logic                 last;
        logic                 err;
    } matrix_elem_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // row_index, col_index, element_value, pad
    logic [KIND_W-1:0]     s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // out_row, out_col, out_value, pad
    logic                  m_axis_tlast;   // last_of_run
    logic                  m_axis_tuser;   // size_error

    // shadow of the block: both element stores and the register file
    logic [DATA_W-1:0] store_a [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] store_b [MAX_DIM*MAX_DIM];
    logic [MODE_W-1:0] cfg_mode;
    logic [DIM_W-1:0]  cfg_rows_a, cfg_cols_a, cfg_rows_b, cfg_cols_b;
    logic [DATA_W-1:0] cfg_scale;

    // result words predicted but not yet seen, newest at the front
    matrix_elem_t pending_elems[$];

    int fail_count       = 0;
    int elems_checked    = 0;
    int size_errors_seen = 0;
    int computes_sent    = 0;
    int words_sent       = 0;
    int cycle_count      = 0;

    // idle controls, shared by the driver, the receiver and the tests
    bit tx_idle_on = 1;
    bit rx_idle_on = 1;
    int rx_gap     = 0;
    int rx_hold    = 0;

    matrix_arith_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words outstanding",
                     $time, cycle_count, pending_elems.size());
            $display("matrix_arith_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // clip to the signed 32-bit range
    function automatic logic signed [63:0] clip_word(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 product: full 64-bit product, floor shift by 16, then clip
    function automatic logic signed [63:0] q_product(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
        logic signed [63:0] wa, wb, p;
        wa = a;
        wb = b;
        p  = wa * wb;
        return clip_word(p >>> 16);
    endfunction

    // 0 counts as 1, anything above the store size as the store size
    function automatic int dim_in_use(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Apply one accepted input word to the shadow and queue the words it causes.
    task automatic model_matrix_word(input logic [KIND_W-1:0]    kind,
                                     input logic [IDX_FLD_W-1:0] row,
                                     input logic [IDX_FLD_W-1:0] col,
                                     input logic [DATA_W-1:0]    value);
        int ra, ca, rb, cb, nr, nc, i, j, k;
        logic signed [63:0] a, b, acc;
        matrix_elem_t e;
        ra = dim_in_use(cfg_rows_a);
        ca = dim_in_use(cfg_cols_a);
        rb = dim_in_use(cfg_rows_b);
        cb = dim_in_use(cfg_cols_b);
        case (kind)
            KIND_LOAD_A: store_a[int'(row) * MAX_DIM + int'(col)] = value;
            KIND_LOAD_B: store_b[int'(row) * MAX_DIM + int'(col)] = value;
            KIND_COMPUTE: begin
                computes_sent++;
                if (((cfg_mode == OP_ADD || cfg_mode == OP_SUB) && (ra != rb || ca != cb)) ||
                    (cfg_mode == OP_MUL && ca != rb)) begin
                    // shape mismatch: a single flagged word, everything else zero
                    e.row   = '0;
                    e.col   = '0;
                    e.value = '0;
                    e.last  = 1'b1;
                    e.err   = 1'b1;
                    pending_elems.push_front(e);
                end else begin
                    nr = ra;
                    nc = (cfg_mode == OP_MUL) ? cb : ca;
                    for (i = 0; i < nr; i++) begin
                        for (j = 0; j < nc; j++) begin
                            a = $signed(store_a[i * MAX_DIM + j]);
                            b = $signed(store_b[i * MAX_DIM + j]);
                            case (cfg_mode)
                                OP_ADD:   acc = clip_word(a + b);
                                OP_SUB:   acc = clip_word(a - b);
                                OP_SCALE: acc = q_product(store_a[i * MAX_DIM + j], cfg_scale);
                                default: begin
                                    // clip after every step of the dot product
                                    acc = 0;
                                    for (k = 0; k < ca; k++)
                                        acc = clip_word(acc +
                                                        q_product(store_a[i * MAX_DIM + k],
                                                                  store_b[k * MAX_DIM + j]));
                                end
                            endcase
                            e.row   = IDX_FLD_W'(i);
                            e.col   = IDX_FLD_W'(j);
                            e.value = acc[DATA_W-1:0];
                            e.last  = (i == nr - 1) && (j == nc - 1);
                            e.err   = 1'b0;
                            pending_elems.push_front(e);
                        end
                    end
                end
            end
            default: ;   // reserved kind: dropped
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: stall control and checking
    // ------------------------------------------------------------------

    // tready changes on the falling edge only; a long hold beats the per-word gap
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_axis_tready = 1'b0;
                rx_gap--;
            end else begin
                m_axis_tready = aresetn;
            end
        end
    end

    task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    endtask

    task automatic check_result_word(input matrix_elem_t got);
        matrix_elem_t want;
        elems_checked++;
        if (got.err)
            size_errors_seen++;
        if (pending_elems.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word, expected none, got %0d/%0d %h last %0b err %0b",
                     $time, got.row, got.col, got.value, got.last, got.err);
            return;
        end
        want = pending_elems.pop_back();
        if (got.row !== want.row)
            report_field("out_row", want.row, got.row);
        if (got.col !== want.col)
            report_field("out_col", want.col, got.col);
        if (got.value !== want.value)
            report_field("out_value", want.value, got.value);
        if (got.last !== want.last)
            report_field("last_of_run", want.last, got.last);
        if (got.err !== want.err)
            report_field("size_error", want.err, got.err);
    endtask

    always @(posedge aclk) begin
        matrix_elem_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.row   = m_axis_tdata[IDX_FLD_W-1:0];
            got.col   = m_axis_tdata[2*IDX_FLD_W-1:IDX_FLD_W];
            got.value = m_axis_tdata[PAYLOAD_W-1:2*IDX_FLD_W];
            got.last  = m_axis_tlast;
            got.err   = m_axis_tuser;
            check_result_word(got);
            rx_gap = rx_idle_on ? $urandom_range(0, 6) : 0;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word after a random gap; returns at the accepting edge with
    // tvalid still high so back-to-back words need no extra assignment.
    task automatic send_word(input logic [KIND_W-1:0]    kind,
                             input logic [IDX_FLD_W-1:0] row,
                             input logic [IDX_FLD_W-1:0] col,
                             input logic [DATA_W-1:0]    value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {2'b00, value, col, row};
        do @(posedge aclk); while (!s_axis_tready);
        model_matrix_word(kind, row, col, value);
        if (kind != KIND_RESERVED)
            words_sent++;
    endtask

    // Stop offering, wait for every predicted word, then let any trailing
    // load retire so the registers can be written safely.
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_elems.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
        case (idx)
            REG_OP_MODE:      cfg_mode   = data[MODE_W-1:0];
            REG_ROWS_A:       cfg_rows_a = data[DIM_W-1:0];
            REG_COLS_A:       cfg_cols_a = data[DIM_W-1:0];
            REG_ROWS_B:       cfg_rows_b = data[DIM_W-1:0];
            REG_COLS_B:       cfg_cols_b = data[DIM_W-1:0];
            REG_SCALE_FACTOR: cfg_scale  = data;
            default: ;
        endcase
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                             input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
        set_reg(REG_ROWS_A, CFG_DATA_W'(ra));
        set_reg(REG_COLS_A, CFG_DATA_W'(ca));
        set_reg(REG_ROWS_B, CFG_DATA_W'(rb));
        set_reg(REG_COLS_B, CFG_DATA_W'(cb));
    endtask

    // mostly small shapes; now and then anything the 4-bit field holds
    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 9) == 0)
            return DIM_W'($urandom_range(0, 15));
        return DIM_W'($urandom_range(1, 3));
    endfunction

    // extremes, full-range noise and modest values around zero
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // fill part of the in-use block of one store; sparse on big shapes
    task automatic load_block(input logic [KIND_W-1:0] kind, input int nr, input int nc);
        int pct, i, j;
        pct = (nr * nc > 16) ? 15 : 75;
        for (i = 0; i < nr; i++)
            for (j = 0; j < nc; j++)
                if ($urandom_range(0, 99) < pct)
                    send_word(kind, IDX_FLD_W'(i), IDX_FLD_W'(j), pick_value());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // out of reset: 1x1 add of two cleared stores
    task automatic test_reset_defaults();
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // positive clipping of add, positive and negative clipping of subtract
    task automatic test_add_sub_clip();
        send_word(KIND_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_SUB));
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        send_word(KIND_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
        send_word(KIND_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // scale with both scale extremes; shape 15 x 0 clamps to 8 x 1
    task automatic test_scale_extremes();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_SCALE));
        set_reg(REG_SCALE_FACTOR, 32'h8000_0000);
        set_shape(4'd15, 4'd0, 4'd2, 4'd3);   // B shape is irrelevant for scale
        send_word(KIND_LOAD_A, 3'd7, 3'd0, 32'hffff_ffff);
        send_word(KIND_LOAD_A, 3'd7, 3'd7, 32'h7fff_ffff);   // outside the shape: stale
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
        set_reg(REG_SCALE_FACTOR, 32'h7fff_ffff);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // 1x2 by 2x1: clipped products, then an accumulator that clips and recovers
    task automatic test_multiply_accumulate();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_MUL));
        set_shape(4'd1, 4'd2, 4'd2, 4'd1);
        send_word(KIND_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_word(KIND_LOAD_A, 3'd0, 3'd1, 32'h7fff_ffff);
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
        send_word(KIND_LOAD_B, 3'd1, 3'd0, 32'h7fff_ffff);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        send_word(KIND_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // mismatched shapes for add and multiply; scale never fails
    task automatic test_size_errors();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_ADD));
        set_shape(4'd2, 4'd1, 4'd1, 4'd1);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_MUL));
        set_shape(4'd1, 4'd3, 4'd2, 4'd1);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_SCALE));
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // reserved kind must leave the stores alone and return nothing
    task automatic test_reserved_kind();
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_ADD));
        set_shape(4'd1, 4'd1, 4'd1, 4'd1);
        send_word(KIND_RESERVED, 3'd0, 3'd0, 32'h1234_5678);
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain_results();
    endtask

    // Full 8x8x8 multiply while the receiver stalls for a long stretch; the
    // sender keeps offering loads so the input side has to hold them off.
    task automatic test_backpressure();
        int i;
        set_reg(REG_OP_MODE, CFG_DATA_W'(OP_MUL));
        set_shape(4'd8, 4'd8, 4'd15, 4'd8);
        tx_idle_on = 1'b0;
        rx_hold    = HOLD_CYCLES;
        send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
        for (i = 0; i < 8; i++)
            send_word(KIND_LOAD_A, IDX_FLD_W'($urandom_range(0, 7)),
                      IDX_FLD_W'($urandom_range(0, 7)), pick_value());
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed runs: shape, loads, compute. Some runs get a bad
    // shape, stray loads, reserved words or a second compute on top.
    task automatic test_random_runs();
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  ra, ca, rb, cb;
        int start, n, i;
        start = words_sent;
        while (words_sent < start + RANDOM_WORDS) begin
            drain_results();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            mode = MODE_W'($urandom_range(0, 3));
            ra = pick_dim();
            ca = pick_dim();
            rb = pick_dim();
            cb = pick_dim();
            if ($urandom_range(0, 4) != 0) begin
                if (mode == OP_MUL) begin
                    rb = ca;
                end else begin
                    rb = ra;
                    cb = ca;
                end
            end
            set_reg(REG_OP_MODE, CFG_DATA_W'(mode));
            set_shape(ra, ca, rb, cb);
            if ($urandom_range(0, 2) == 0)
                set_reg(REG_SCALE_FACTOR, pick_value());
            load_block(KIND_LOAD_A, dim_in_use(ra), dim_in_use(ca));
            if (mode != OP_SCALE)
                load_block(KIND_LOAD_B, dim_in_use(rb), dim_in_use(cb));
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < n; i++)
                send_word(KIND_W'($urandom_range(0, 3)), IDX_FLD_W'($urandom_range(0, 7)),
                          IDX_FLD_W'($urandom_range(0, 7)), $urandom);
            send_word(KIND_COMPUTE, IDX_FLD_W'($urandom_range(0, 7)),
                      IDX_FLD_W'($urandom_range(0, 7)), $urandom);
            if ($urandom_range(0, 3) == 0) begin
                // loads right behind a compute, then compute again on the new data
                send_word(KIND_LOAD_A, 3'd0, 3'd0, pick_value());
                send_word(KIND_LOAD_B, 3'd0, 3'd0, pick_value());
                send_word(KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int i;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (i = 0; i < MAX_DIM * MAX_DIM; i++) begin
            store_a[i] = '0;
            store_b[i] = '0;
        end
        cfg_mode   = OP_ADD;
        cfg_rows_a = 4'd1;
        cfg_cols_a = 4'd1;
        cfg_rows_b = 4'd1;
        cfg_cols_b = 4'd1;
        cfg_scale  = SCALE_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_add_sub_clip();
        test_scale_extremes();
        test_multiply_accumulate();
        test_size_errors();
        test_reserved_kind();
        test_backpressure();
        test_random_runs();
        drain_results();

        $display("run covered %0d input words, %0d computes, %0d result words (%0d size errors)",
                 words_sent, computes_sent, elems_checked, size_errors_seen);
        $display("all four ops, shape clamping, clipping, reserved kind, long output stall");
        if (fail_count == 0) begin
            $display("matrix_arith_unit_tb passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("matrix_arith_unit_tb failed");
        end
        $finish;
    end

endmodule
